FILE: hdl/lfu_pkg.sv
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int OCC_BITS   = $clog2(CAPACITY + 1);
    localparam int CAP_BITS   = 5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } lfu_req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } lfu_rsp_t;

    // what travels along the scan chain
    typedef struct packed {
        logic                  hit;
        logic [SLOT_BITS-1:0]  hit_slot;
        logic [31:0]           hit_value;
        logic [SLOT_BITS-1:0]  hit_rank;
        logic                  has_victim;
        logic [SLOT_BITS-1:0]  vic_slot;
        logic [COUNT_BITS-1:0] vic_count;
        logic [SLOT_BITS-1:0]  vic_rank;
        logic [31:0]           vic_key;
        logic                  has_free;
        logic [SLOT_BITS-1:0]  free_slot;
    } lfu_scan_t;

    // broadcast update to every cell
    typedef struct packed {
        logic                 touch;
        logic [SLOT_BITS-1:0] touch_slot;
        logic [SLOT_BITS-1:0] touch_rank;
        logic                 write_value;
        logic                 insert;
        logic [SLOT_BITS-1:0] insert_slot;
        logic                 evict;
        logic [SLOT_BITS-1:0] evict_rank;
        logic [31:0]          key;
        logic [31:0]          value;
    } lfu_upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_OUTPUT
    } lfu_state_t;
endpackage

FILE: hdl/lfu_cell.sv
`timescale 1ns / 1ps
module lfu_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lfu_pkg::SLOT_BITS-1:0] slot_id,
    input  logic                         scan_en,
    input  logic                         scan_clear,
    input  logic [31:0]                  scan_key,
    input  lfu_pkg::lfu_scan_t           scan_in,
    output lfu_pkg::lfu_scan_t           scan_out,
    input  logic                         upd_en,
    input  lfu_pkg::lfu_upd_t            upd
);
    import lfu_pkg::*;

    logic                  valid_reg;
    logic [31:0]           key_reg;
    logic [31:0]           value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [SLOT_BITS-1:0]  rank_reg;
    lfu_scan_t             scan_reg;
    lfu_scan_t             scan_next;
    logic                  better;
    logic [SLOT_BITS-1:0]  rank_next;
    logic                  me_touch;
    logic                  me_insert;
    logic                  me_evict;

    assign scan_out = scan_reg;

    // this cell compares itself against what the previous cell handed over
    always_comb
    begin
        scan_next = scan_in;
        better = !scan_in.has_victim || (count_reg < scan_in.vic_count)
            || ((count_reg == scan_in.vic_count) && (rank_reg > scan_in.vic_rank));
        if (valid_reg)
        begin
            if (!scan_in.hit && key_reg == scan_key)
            begin
                scan_next.hit       = 1'b1;
                scan_next.hit_slot  = slot_id;
                scan_next.hit_value = value_reg;
                scan_next.hit_rank  = rank_reg;
            end
            if (better)
            begin
                scan_next.has_victim = 1'b1;
                scan_next.vic_slot   = slot_id;
                scan_next.vic_count  = count_reg;
                scan_next.vic_rank   = rank_reg;
                scan_next.vic_key    = key_reg;
            end
        end
        else if (!scan_in.has_free)
        begin
            scan_next.has_free  = 1'b1;
            scan_next.free_slot = slot_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (scan_clear)
        begin
            scan_reg <= '0;
        end
        else if (scan_en)
        begin
            scan_reg <= scan_next;
        end
    end

    assign me_touch  = upd.touch && upd.touch_slot == slot_id;
    assign me_insert = upd.insert && upd.insert_slot == slot_id;
    assign me_evict  = upd.evict && upd.insert_slot == slot_id;

    always_comb
    begin
        rank_next = rank_reg;
        if (upd.touch && rank_reg < upd.touch_rank)
        begin
            rank_next = rank_reg + 1'b1;
        end
        if (upd.insert)
        begin
            if (upd.evict && rank_reg > upd.evict_rank)
            begin
                rank_next = rank_reg;
            end
            else
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (upd_en && me_insert)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            if (me_insert)
            begin
                key_reg   <= upd.key;
                value_reg <= upd.value;
                count_reg <= COUNT_BITS'(1);
                rank_reg  <= '0;
            end
            else if (me_touch)
            begin
                if (upd.write_value)
                begin
                    value_reg <= upd.value;
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                rank_reg <= '0;
            end
            else if (valid_reg && !me_evict)
            begin
                rank_reg <= rank_next;
            end
        end
    end
endmodule

FILE: hdl/lfu_cache_replacement_unit.sv
`timescale 1ns / 1ps
// LFU key-value store with LRU tie-break over CAPACITY slots held in a row of
// cells. A request is taken when idle; the search, minimum-count and
// oldest-touch scan moves through the cell chain one cell per cycle, then
// the update state follows and the response sits in an output register.
// The next request is accepted once the response register has been handed on.
module lfu_cache_replacement_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lfu_pkg::lfu_req_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output lfu_pkg::lfu_rsp_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [lfu_pkg::CAP_BITS-1:0] cfg_data
);
    import lfu_pkg::*;

    lfu_state_t             state_reg, state_next;
    logic [SLOT_BITS:0]     step_reg, step_next;
    lfu_req_t               req_reg;
    lfu_rsp_t               rsp_reg, rsp_next;
    logic [CAP_BITS-1:0]    cap_reg;
    logic [OCC_BITS-1:0]    occ_reg, occ_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   scan_en, scan_clear, upd_en, req_take;
    lfu_scan_t              chain [CAPACITY+1];
    lfu_scan_t              res;
    lfu_upd_t               upd;
    logic [CAP_BITS:0]      cap_eff;
    logic                   full;

    assign chain[0] = '0;
    assign res      = chain[CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : gen_cell
            lfu_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .slot_id   (SLOT_BITS'(g)),
                .scan_en   (scan_en),
                .scan_clear(scan_clear),
                .scan_key  (req_reg.lookup_key),
                .scan_in   (chain[g]),
                .scan_out  (chain[g+1]),
                .upd_en    (upd_en),
                .upd       (upd)
            );
        end
    endgenerate

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign req_take  = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    assign cap_eff = (cap_reg > CAPACITY) ? (CAP_BITS+1)'(CAPACITY) : (CAP_BITS+1)'(cap_reg);
    assign full    = (CAP_BITS+1)'(occ_reg) >= cap_eff;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == (SLOT_BITS+1)'(CAPACITY - 1))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        scan_en    = 1'b0;
        scan_clear = 1'b0;
        upd_en     = 1'b0;
        case (state_reg)
            ST_IDLE:   scan_clear = 1'b1;
            ST_SCAN:   scan_en = 1'b1;
            ST_UPDATE: upd_en = 1'b1;
            default:   scan_en = 1'b0;
        endcase
    end

    always_comb
    begin
        upd            = '0;
        upd.key        = req_reg.lookup_key;
        upd.value      = req_reg.store_value;
        upd.touch_slot = res.hit_slot;
        upd.touch_rank = res.hit_rank;
        upd.evict_rank = res.vic_rank;
        rsp_next       = '0;
        rsp_next.found = res.hit;
        rsp_next.read_value = '1;
        occ_next       = occ_reg;
        if (res.hit)
        begin
            if (req_reg.command == CMD_GET)
            begin
                upd.touch           = 1'b1;
                rsp_next.read_value = res.hit_value;
            end
            else if (cap_eff != '0)
            begin
                upd.touch       = 1'b1;
                upd.write_value = 1'b1;
            end
        end
        else if (req_reg.command == CMD_PUT && cap_eff != '0)
        begin
            if (full && res.has_victim)
            begin
                upd.insert           = 1'b1;
                upd.evict            = 1'b1;
                upd.insert_slot      = res.vic_slot;
                rsp_next.evicted     = 1'b1;
                rsp_next.evicted_key = res.vic_key;
            end
            else if (res.has_free)
            begin
                upd.insert      = 1'b1;
                upd.insert_slot = res.free_slot;
                occ_next        = occ_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_UPDATE)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            occ_reg       <= '0;
            cap_reg       <= CAP_BITS'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (upd_en)
            begin
                occ_reg <= occ_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= in_data;
        end
        if (upd_en)
        begin
            rsp_reg <= rsp_next;
        end
    end

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_BITS'(CAPACITY))
        else $error("occupancy above capacity");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req_take)
        else $error("request taken while busy");
    a_rsp_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPDATE |=> out_valid_reg)
        else $error("response missing after update");
    a_evict_only_put: assert property (@(posedge clk) disable iff (!rst_n)
        upd_en && rsp_next.evicted |-> req_reg.command == CMD_PUT && !res.hit)
        else $error("eviction on get or hit");
`endif
endmodule
